[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// Block buffer cache package
// Shared types and codes for the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Action codes as they arrive on the input channel.
    localparam logic [1:0] ACT_GET   = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // Decoded operation carried through the command queue.
    typedef enum logic [1:0] {
        OP_GET,
        OP_MARK,
        OP_FLUSH,
        OP_NOP
    } t_op;

    // Result kinds on the output channel.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    // One classified command as held in the queue.
    typedef struct packed {
        t_op         op;
        logic [31:0] block;
        logic [31:0] sector;
        logic [63:0] now;
    } t_cmd;

    // Width of one tag store entry: tag above last-use time.
    localparam int TAG_W   = 32;
    localparam int TIME_W  = 64;
    localparam int ENTRY_W = TAG_W + TIME_W;

endpackage

[rtl/block_buffer_cache_lru.sv]
// ----------------------------------------------------------------------------
// LRU write-back block buffer cache, tag and policy engine
// Looks up blocks, picks victims by least recent use, and issues the disk
// write-back and refill commands of the cache; also marks and flushes.
//
// Channel   Direction  Handshake                    Carries
// request   in         i_in_valid / o_in_ready      action, block number, time
// result    out        o_out_valid / i_out_ready    kind, sector, index, flags
// config    in         i_cfg_valid / o_cfg_ready    disk offset in sectors
//
// A get scans the tag store, which is read one entry a cycle, and then
// issues its result items in order. A flush walks every entry, writes back
// each dirty one and ends with its done item. Mark and undefined actions
// give only a done item.
// A two-entry queue lets requests be taken while the back end is busy.
// Reset is synchronous and active low; the tag store needs no clearing pass.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru #(
    parameter int ENTRIES = 8,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic [31:0]      i_block_number,
    input  logic [63:0]      i_now,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_sector,
    output logic [IDX_W-1:0] o_buffer_index,
    output logic             o_half,
    output logic             o_hit,
    output logic             o_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [31:0]      i_cfg_data
);

    logic [31:0]   r_disk_offset;
    logic          w_cmd_valid;
    logic          w_cmd_pop;
    bbc_pkg::t_cmd w_cmd;

    // Disk offset register; a write is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_offset <= '0;
        end else if (i_cfg_valid) begin
            r_disk_offset <= i_cfg_data;
        end
    end

    // Request decode and command queue.
    bbc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .i_now          (i_now),
        .i_disk_offset  (r_disk_offset),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    // Tag store, policy and result sequencing.
    bbc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_disk_offset  (r_disk_offset),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_sector       (o_sector),
        .o_buffer_index (o_buffer_index),
        .o_half         (o_half),
        .o_hit          (o_hit),
        .o_last         (o_last)
    );

endmodule

[rtl/bbc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bbc_front.sv]
// ----------------------------------------------------------------------------
// Block buffer cache front end
// Accepts requests, decodes the action, works out the first sector of the
// requested block and queues the command for the back end.
// ----------------------------------------------------------------------------
module bbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  logic [31:0]   i_block_number,
    input  logic [63:0]   i_now,
    input  logic [31:0]   i_disk_offset,
    output logic          o_cmd_valid,
    output bbc_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    bbc_pkg::t_cmd  w_cmd;
    bbc_pkg::t_cmd  r_q [QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           w_push;

    // Classify the request and form the sector of its first half.
    always_comb begin
        w_cmd.block  = i_block_number;
        w_cmd.now    = i_now;
        w_cmd.sector = i_disk_offset + {i_block_number[30:0], 1'b0};
        unique case (i_action)
            bbc_pkg::ACT_GET:   w_cmd.op = bbc_pkg::OP_GET;
            bbc_pkg::ACT_MARK:  w_cmd.op = bbc_pkg::OP_MARK;
            bbc_pkg::ACT_FLUSH: w_cmd.op = bbc_pkg::OP_FLUSH;
            default:            w_cmd.op = bbc_pkg::OP_NOP;
        endcase
    end

    assign o_in_ready  = (r_cnt != QCW'(QDEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/bbc_back.sv]
// ----------------------------------------------------------------------------
// Block buffer cache back end
// Carries out queued commands against the tag store: lookup and victim scan,
// write-back, refill, mark dirty and flush, and issues the result items.
// ----------------------------------------------------------------------------
module bbc_back #(
    parameter int ENTRIES = 8,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_disk_offset,
    input  logic             i_cmd_valid,
    input  bbc_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_sector,
    output logic [IDX_W-1:0] o_buffer_index,
    output logic             o_half,
    output logic             o_hit,
    output logic             o_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_FL_CHK,
        S_FL_TAG,
        S_WR0,
        S_WR1,
        S_RD0,
        S_RD1,
        S_DONE
    } t_state;

    t_state                          r_state;
    bbc_pkg::t_cmd                   r_cmd;
    logic [IDX_W-1:0]                r_scan;
    logic                            r_rd_pend;
    logic [IDX_W-1:0]                r_rd_idx;
    logic                            r_hit_found;
    logic [IDX_W-1:0]                r_hit_idx;
    logic                            r_inv_found;
    logic [IDX_W-1:0]                r_inv_idx;
    logic [bbc_pkg::TIME_W-1:0]      r_best;
    logic [IDX_W-1:0]                r_best_idx;
    logic [bbc_pkg::TAG_W-1:0]       r_best_tag;
    logic [ENTRIES-1:0]              r_valid;
    logic [ENTRIES-1:0]              r_dirty;
    logic [IDX_W-1:0]                r_recent;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_hit;
    logic [31:0]                     r_sec;
    logic                            r_out_vld;
    bbc_pkg::t_kind                  r_out_kind;
    logic [31:0]                     r_out_sec;
    logic [IDX_W-1:0]                r_out_idx;
    logic                            r_out_half;
    logic                            r_out_hit;
    logic                            r_out_last;

    logic                            w_free;
    logic                            w_emit;
    logic                            w_ram_we;
    logic [IDX_W-1:0]                w_ram_waddr;
    logic                            w_ram_re;
    logic [IDX_W-1:0]                w_ram_raddr;
    logic [bbc_pkg::ENTRY_W-1:0]     w_ram_rdata;
    logic [bbc_pkg::TAG_W-1:0]       w_rd_tag;
    logic [bbc_pkg::TIME_W-1:0]      w_rd_time;
    logic                            w_rd_vld;
    logic [IDX_W-1:0]                w_victim;

    // Tag and last-use time of every entry.
    bbc_ram #(
        .WIDTH (bbc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata ({r_cmd.block, r_cmd.now}),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd_tag  = w_ram_rdata[bbc_pkg::ENTRY_W-1:bbc_pkg::TIME_W];
    assign w_rd_time = w_ram_rdata[bbc_pkg::TIME_W-1:0];
    assign w_rd_vld  = r_valid[r_rd_idx];
    assign w_victim  = r_inv_found ? r_inv_idx : r_best_idx;

    // The output register can take a new item this cycle.
    assign w_free    = !r_out_vld || i_out_ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // A result state loads the output register when it is free.
    assign w_emit = w_free && ((r_state == S_WR0) || (r_state == S_WR1) ||
                               (r_state == S_RD0) || (r_state == S_RD1) ||
                               (r_state == S_DONE));

    // Tag store access: reads during the scan and the flush walk, one write
    // when a get is resolved.
    always_comb begin
        w_ram_re    = 1'b0;
        w_ram_raddr = r_scan;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_hit_found ? r_hit_idx : w_victim;
        unique case (r_state)
            S_SCAN:   w_ram_re = 1'b1;
            S_FL_CHK: w_ram_re = r_valid[r_scan] && r_dirty[r_scan];
            S_DECIDE: w_ram_we = 1'b1;
            default:  w_ram_re = 1'b0;
        endcase
    end

    // Sequencer with its state, tracking registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_hit_found <= 1'b0;
            r_inv_found <= 1'b0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_recent    <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            // Output register fills on a new item and drains when taken.
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            // Compare one tag store entry per cycle while scanning. Entry zero
            // always seeds the candidate, so its tag is known when it is the
            // victim by default.
            r_rd_pend <= (r_state == S_SCAN);
            r_rd_idx  <= r_scan;
            if (r_rd_pend) begin
                if (!r_hit_found && w_rd_vld && (w_rd_tag == r_cmd.block)) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_rd_idx;
                end
                if (!r_inv_found) begin
                    if (!w_rd_vld) begin
                        r_inv_found <= 1'b1;
                        r_inv_idx   <= r_rd_idx;
                    end else if ((w_rd_time < r_best) || (r_rd_idx == '0)) begin
                        r_best      <= w_rd_time;
                        r_best_idx  <= r_rd_idx;
                        r_best_tag  <= w_rd_tag;
                    end
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_hit <= 1'b0;
                        r_scan <= '0;
                        unique case (i_cmd.op)
                            bbc_pkg::OP_GET: begin
                                r_hit_found <= 1'b0;
                                r_inv_found <= 1'b0;
                                r_best      <= '1;
                                r_best_idx  <= '0;
                                r_state     <= S_SCAN;
                            end
                            bbc_pkg::OP_MARK: begin
                                if (r_valid[r_recent]) begin
                                    r_dirty[r_recent] <= 1'b1;
                                end
                                r_idx   <= r_recent;
                                r_state <= S_DONE;
                            end
                            bbc_pkg::OP_FLUSH: begin
                                r_state <= S_FL_CHK;
                            end
                            bbc_pkg::OP_NOP: begin
                                r_idx   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_scan == LAST_IDX) begin
                        r_state <= S_SCAN_END;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_SCAN_END: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_hit_found) begin
                        r_recent <= r_hit_idx;
                        r_idx    <= r_hit_idx;
                        r_hit    <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_valid[w_victim] <= 1'b1;
                        r_dirty[w_victim] <= 1'b0;
                        r_recent <= w_victim;
                        r_idx    <= w_victim;
                        r_sec    <= i_disk_offset + {r_best_tag[30:0], 1'b0};
                        if (!r_inv_found && r_dirty[w_victim]) begin
                            r_state <= S_WR0;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_FL_CHK: begin
                    if (r_valid[r_scan] && r_dirty[r_scan]) begin
                        r_idx   <= r_scan;
                        r_state <= S_FL_TAG;
                    end else if (r_scan == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_FL_TAG: begin
                    r_sec   <= i_disk_offset + {w_rd_tag[30:0], 1'b0};
                    r_state <= S_WR0;
                end
                S_WR0: begin
                    if (w_free) begin
                        r_out_kind <= bbc_pkg::KIND_WRITE;
                        r_out_sec  <= r_sec;
                        r_out_idx  <= r_idx;
                        r_out_half <= 1'b0;
                        r_out_hit  <= 1'b0;
                        r_out_last <= 1'b0;
                        r_sec      <= r_sec + 1'b1;
                        r_state    <= S_WR1;
                    end
                end
                S_WR1: begin
                    if (w_free) begin
                        r_out_kind <= bbc_pkg::KIND_WRITE;
                        r_out_sec  <= r_sec;
                        r_out_idx  <= r_idx;
                        r_out_half <= 1'b1;
                        r_out_hit  <= 1'b0;
                        r_out_last <= 1'b0;
                        if (r_cmd.op == bbc_pkg::OP_FLUSH) begin
                            // The refill of a get clears its own dirty mark.
                            r_dirty[r_idx] <= 1'b0;
                            if (r_scan == LAST_IDX) begin
                                r_idx   <= '0;
                                r_state <= S_DONE;
                            end else begin
                                r_scan  <= r_scan + 1'b1;
                                r_state <= S_FL_CHK;
                            end
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    if (w_free) begin
                        r_out_kind <= bbc_pkg::KIND_READ;
                        r_out_sec  <= r_cmd.sector;
                        r_out_idx  <= r_idx;
                        r_out_half <= 1'b0;
                        r_out_hit  <= 1'b0;
                        r_out_last <= 1'b0;
                        r_state    <= S_RD1;
                    end
                end
                S_RD1: begin
                    if (w_free) begin
                        r_out_kind <= bbc_pkg::KIND_READ;
                        r_out_sec  <= r_cmd.sector + 1'b1;
                        r_out_idx  <= r_idx;
                        r_out_half <= 1'b1;
                        r_out_hit  <= 1'b0;
                        r_out_last <= 1'b0;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_free) begin
                        r_out_kind <= bbc_pkg::KIND_DONE;
                        r_out_sec  <= '0;
                        r_out_idx  <= r_idx;
                        r_out_half <= 1'b0;
                        r_out_hit  <= r_hit;
                        r_out_last <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_kind         = r_out_kind;
    assign o_sector       = r_out_sec;
    assign o_buffer_index = r_out_idx;
    assign o_half         = r_out_half;
    assign o_hit          = r_out_hit;
    assign o_last         = r_out_last;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the LRU block buffer cache engine
// Requests are queued by a stimulus process and offered by a clocked driver.
// Each accepted request is run through a behavioural copy of the tag store,
// and the disk commands and done items it yields are compared in order with
// what the engine returns. The run steps through several disk offsets, with
// random gaps on both channels, one long stall of the result channel and
// one stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          ENTRIES        = 8;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          POOL_SIZE      = 12;
    localparam logic [1:0]  ACT_UNDEF      = 2'd3;
    localparam logic [63:0] STAMP_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] block;
        logic [63:0] stamp;
    } t_request;

    typedef struct {
        bbc_pkg::t_kind kind;
        logic [31:0]    sector;
        logic [2:0]     entry;
        logic           half;
        logic           hit;
        logic           last;
    } t_cache_result;

    // Clock, reset and block ports.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action       = bbc_pkg::ACT_GET;
    logic [31:0] i_block_number = '0;
    logic [63:0] i_now          = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_sector;
    logic [2:0]  o_buffer_index;
    logic        o_half;
    logic        o_hit;
    logic        o_last;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data     = '0;

    // Shared testbench state.
    t_request      pending_requests[$];
    t_cache_result expected_results[$];
    int            mismatches   = 0;
    int            quiet_cycles = 0;
    logic          calm         = 1'b0;
    logic          hold_toggle  = 1'b0;
    logic          hold_seen    = 1'b0;
    int            hold_left    = 0;
    logic [63:0]   tick_now     = '0;
    logic [31:0]   block_pool[POOL_SIZE];

    // Behavioural copy of the tag store and the offset register.
    logic [31:0] line_tag[ENTRIES];
    logic        line_valid[ENTRIES];
    logic        line_dirty[ENTRIES];
    logic [63:0] line_time[ENTRIES];
    logic [2:0]  recent_line = '0;
    logic [31:0] disk_offset = '0;

    block_buffer_cache_lru #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .i_now          (i_now),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_sector       (o_sector),
        .o_buffer_index (o_buffer_index),
        .o_half         (o_half),
        .o_hit          (o_hit),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_time[i]  = '0;
        end
    end

    function automatic void expect_result(bbc_pkg::t_kind kind, logic [31:0] sector,
                                          logic [2:0] entry, logic half, logic hit,
                                          logic last);
        t_cache_result r;
        r.kind   = kind;
        r.sector = sector;
        r.entry  = entry;
        r.half   = half;
        r.hit    = hit;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic logic [31:0] block_sector(logic [31:0] blk);
        return disk_offset + {blk[30:0], 1'b0};
    endfunction

    // A dirty valid line sends both of its sectors back to disk and turns clean.
    function automatic void write_back_line(int i);
        logic [31:0] sec;
        if (line_valid[i] && line_dirty[i]) begin
            sec = block_sector(line_tag[i]);
            expect_result(bbc_pkg::KIND_WRITE, sec, 3'(i), 1'b0, 1'b0, 1'b0);
            expect_result(bbc_pkg::KIND_WRITE, sec + 32'd1, 3'(i), 1'b1, 1'b0, 1'b0);
            line_dirty[i] = 1'b0;
        end
    endfunction

    // Works out the commands and the done item that one request yields.
    function automatic void predict_cache_results(logic [1:0] act, logic [31:0] blk,
                                                  logic [63:0] stamp);
        int          i;
        int          victim;
        logic [63:0] oldest;
        logic [31:0] sec;
        victim = 0;
        oldest = STAMP_MAX;
        case (act)
            bbc_pkg::ACT_GET: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (line_valid[i] && line_tag[i] == blk) begin
                        line_time[i] = stamp;
                        recent_line  = 3'(i);
                        expect_result(bbc_pkg::KIND_DONE, '0, 3'(i), 1'b0, 1'b1, 1'b1);
                        return;
                    end
                end
                // Miss: first free line, else the strictly oldest one.
                for (i = 0; i < ENTRIES; i++) begin
                    if (!line_valid[i]) begin
                        victim = i;
                        break;
                    end
                    if (line_time[i] < oldest) begin
                        oldest = line_time[i];
                        victim = i;
                    end
                end
                write_back_line(victim);
                sec = block_sector(blk);
                expect_result(bbc_pkg::KIND_READ, sec, 3'(victim), 1'b0, 1'b0, 1'b0);
                expect_result(bbc_pkg::KIND_READ, sec + 32'd1, 3'(victim), 1'b1, 1'b0, 1'b0);
                line_tag[victim]   = blk;
                line_valid[victim] = 1'b1;
                line_dirty[victim] = 1'b0;
                line_time[victim]  = stamp;
                recent_line        = 3'(victim);
                expect_result(bbc_pkg::KIND_DONE, '0, 3'(victim), 1'b0, 1'b0, 1'b1);
            end
            bbc_pkg::ACT_MARK: begin
                if (line_valid[recent_line]) line_dirty[recent_line] = 1'b1;
                expect_result(bbc_pkg::KIND_DONE, '0, recent_line, 1'b0, 1'b0, 1'b1);
            end
            bbc_pkg::ACT_FLUSH: begin
                for (i = 0; i < ENTRIES; i++) write_back_line(i);
                expect_result(bbc_pkg::KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                expect_result(bbc_pkg::KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Request driver: predicts on each transfer, then offers the next request.
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_cache_results(i_action, i_block_number, i_now);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
                    req = pending_requests.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= req.action;
                    i_block_number <= req.block;
                    i_now          <= req.stamp;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Result monitor: every transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d sector 0x%0h",
                       o_kind, o_sector);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", want.kind, o_kind);
                compare_field("sector", want.sector, o_sector);
                compare_field("buffer_index", want.entry, o_buffer_index);
                compare_field("half", want.half, o_half);
                compare_field("hit", want.hit, o_hit);
                compare_field("last", want.last, o_last);
            end
        end
    end

    // Watchdog: ends the run once no channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_request(logic [1:0] act, logic [31:0] blk, logic [63:0] stamp);
        t_request req;
        req.action = act;
        req.block  = blk;
        req.stamp  = stamp;
        pending_requests.push_back(req);
    endtask

    // Mostly rising time stamps, so that the LRU order means something.
    function automatic logic [63:0] next_stamp();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            tick_now = tick_now + 64'($urandom_range(50, 1));
            return tick_now;
        end else if (roll < 80) begin
            return {$urandom, $urandom};
        end else if (roll < 90) begin
            return STAMP_MAX;
        end else if (roll < 95) begin
            return '0;
        end
        return tick_now;
    endfunction

    // Gets from a small block pool so that hits, misses and evictions mix;
    // a get is often followed by a mark, as a writer would do.
    task automatic queue_random_requests(int count);
        int          roll;
        logic [31:0] blk;
        for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = $urandom;
        block_pool[0] = '0;
        block_pool[1] = '1;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            blk  = ($urandom_range(99) < 80) ? block_pool[$urandom_range(POOL_SIZE - 1)]
                                             : $urandom;
            if (roll < 60) begin
                queue_request(bbc_pkg::ACT_GET, blk, next_stamp());
                if ($urandom_range(1) == 1 && n + 1 < count) begin
                    queue_request(bbc_pkg::ACT_MARK, $urandom, next_stamp());
                    n++;
                end
            end else if (roll < 78) begin
                queue_request(bbc_pkg::ACT_MARK, blk, next_stamp());
            end else if (roll < 94) begin
                queue_request(bbc_pkg::ACT_FLUSH, blk, next_stamp());
            end else begin
                queue_request(ACT_UNDEF, blk, next_stamp());
            end
        end
    endtask

    task automatic write_offset(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        disk_offset = value;
    endtask

    // Holds the sender back until every request has produced all its results.
    task automatic wait_for_drain();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_offset(32'd0);

        // Directed: empty cache, hits, dirty evictions and all-ones time stamps.
        queue_request(bbc_pkg::ACT_MARK, 32'd0, 64'd0);
        queue_request(bbc_pkg::ACT_FLUSH, 32'd0, 64'd0);
        queue_request(ACT_UNDEF, 32'hFFFF_FFFF, STAMP_MAX);
        queue_request(bbc_pkg::ACT_GET, 32'd0, 64'd0);
        queue_request(bbc_pkg::ACT_GET, 32'd0, 64'd5);
        queue_request(bbc_pkg::ACT_MARK, 32'd0, 64'd6);
        queue_request(bbc_pkg::ACT_GET, 32'hFFFF_FFFF, STAMP_MAX);
        queue_request(bbc_pkg::ACT_MARK, 32'd0, 64'd7);
        for (int b = 1; b <= 6; b++) queue_request(bbc_pkg::ACT_GET, 32'(b), STAMP_MAX);
        queue_request(bbc_pkg::ACT_GET, 32'd7, 64'd3);
        queue_request(bbc_pkg::ACT_GET, 32'd7, STAMP_MAX);
        queue_request(bbc_pkg::ACT_GET, 32'd8, 64'd9);
        queue_request(bbc_pkg::ACT_MARK, 32'd0, 64'd10);
        queue_request(bbc_pkg::ACT_FLUSH, 32'd0, 64'd11);
        queue_request(bbc_pkg::ACT_GET, 32'hFFFF_FFFF, 64'd0);
        queue_request(bbc_pkg::ACT_FLUSH, 32'hFFFF_FFFF, STAMP_MAX);
        wait_for_drain();

        // Largest offset, so that sector numbers wrap past zero.
        write_offset(32'hFFFF_FFFF);
        queue_random_requests(112);
        wait_for_drain();

        // Random offset, with the result channel held off while requests pile up.
        write_offset($urandom);
        queue_random_requests(112);
        @(posedge i_clk);
        hold_toggle <= ~hold_toggle;
        wait_for_drain();

        // Offset near the top, with no gaps on either side.
        write_offset(32'hFFFF_FFF0 | $urandom_range(15));
        calm <= 1'b1;
        queue_random_requests(112);
        wait_for_drain();

        calm <= 1'b0;
        write_offset(32'd0);
        queue_random_requests(112);
        wait_for_drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
